// ----- rtl/wtcw_pkg.sv -----
// Package for the windowed text console writer: sizes, codes, window geometry and sequencer states.
package wtcw_pkg;

	// Store geometry
	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int HALF_COLUMNS   = SCREEN_COLUMNS / 2;
	localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ADDR_W         = $clog2(CELL_COUNT);
	localparam int CELL_W         = 16;

	// Operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Window numbers
	localparam int         WIN_COUNT = 5;
	localparam logic [2:0] WIN_IN    = 3'd0;
	localparam logic [2:0] WIN_ERR   = 3'd2;
	localparam logic [2:0] WIN_LEFT  = 3'd3;
	localparam logic [2:0] WIN_RIGHT = 3'd4;

	// Window rows
	localparam logic [4:0] IN_TOP    = 5'd22;
	localparam logic [4:0] IN_ROWS   = 5'd3;
	localparam logic [4:0] MAIN_ROWS = 5'd21;

	// Character and attribute codes
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] BKSP_CODE  = 8'h08;
	localparam logic [7:0] NL_CODE    = 8'h0A;
	localparam logic [7:0] ATTR_GREY  = 8'h07;
	localparam logic [7:0] ATTR_RED   = 8'h04;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_LAST_RD,
		ST_LAST_WR,
		ST_PUT,
		ST_BKSP,
		ST_WIPE,
		ST_DONE
	} state_t;

	function automatic logic [4:0] win_top(input logic [2:0] w);
		return (w == WIN_IN) ? IN_TOP : 5'd0;
	endfunction

	// One past the last row of the window: a cursor here means a scroll is due
	function automatic logic [4:0] win_bottom(input logic [2:0] w);
		return (w == WIN_IN) ? 5'(IN_TOP + IN_ROWS) : MAIN_ROWS;
	endfunction

	function automatic logic [6:0] win_left(input logic [2:0] w);
		return (w == WIN_RIGHT) ? 7'(HALF_COLUMNS) : 7'd0;
	endfunction

	function automatic logic [7:0] win_width(input logic [2:0] w);
		return (w >= WIN_LEFT) ? 8'(HALF_COLUMNS) : 8'(SCREEN_COLUMNS);
	endfunction

	function automatic logic [6:0] win_col_end(input logic [2:0] w);
		return 7'({1'b0, win_left(w)} + win_width(w) - 8'd1);
	endfunction

	function automatic logic in_store(input logic [4:0] row, input logic [6:0] col);
		return (8'(row) < 8'(SCREEN_ROWS)) && (8'(col) < 8'(SCREEN_COLUMNS));
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] row,
			input logic [6:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col));
	endfunction

endpackage

// ----- rtl/windowed_text_console_writer.sv -----
// Top level of the windowed text console writer: sequencer, cell store and cursors.
//
// Input channel (in_valid / in_stall) carries one command item: put a character into a
// window, read one cell, or clear a window. Output channel (out_valid / out_stall) returns
// one result item per command: the read cell (zero for other commands) and the selected
// window's cursor after the command.
// One cell-store write port and one read port under a small sequencer do all work, one cell
// per cycle for writes; where a cell is copied it is read, then written.
// A newline blanks the cells up to the end of the line, and a clear blanks every cell of
// the window. A put at a full window first scrolls it up one row and blanks the last row.
// A put or clear at a bad window and an unused op give a result without touching the store.
// The block takes no item while it works on one. A finished result sits in the output
// register; the next item is accepted while it waits, and that item's result waits in
// the sequencer until the receiver takes the earlier one.
// After reset the store is swept to zero, one cell per cycle, over all SCREEN_ROWS *
// SCREEN_COLUMNS cells (2000) before the first item is accepted. Cursors reset to
// each window's origin.
module windowed_text_console_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [2:0] window_index,
	input  logic [7:0] char_code,
	input  logic [3:0] fg_color,
	input  logic [3:0] bg_color,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_col
);
	import wtcw_pkg::*;

	state_t state_q, state_d;

	// Store with one write port and one registered read port
	logic [CELL_W-1:0] text_mem [CELL_COUNT];
	logic [CELL_W-1:0] mem_rd_q;
	logic              rd_ok_q, rd_ok_d;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] clr_q;

	// Latched item
	logic [1:0] op_q;
	logic [2:0] w_q;
	logic [7:0] ch_q;
	logic [7:0] attr_q;
	logic [4:0] rrow_q;
	logic [6:0] rcol_q;

	// Cursors
	logic [4:0] cur_row_q [WIN_COUNT];
	logic [6:0] cur_col_q [WIN_COUNT];
	logic       cur_we;
	logic [4:0] cur_row_d;
	logic [6:0] cur_col_d;

	// Sweep position and read result
	logic [4:0]        row_q, row_d;
	logic [6:0]        col_q, col_d;
	logic [CELL_W-1:0] cell_q, cell_d;

	// Output register
	logic       out_valid_q;
	logic [7:0] cell_char_q, cell_attr_q;
	logic [4:0] cursor_row_q;
	logic [6:0] cursor_col_q;

	// Window geometry of the selected window
	logic       w_ok, is_nl, at_end, out_free;
	logic [4:0] top, bottom, last, cr;
	logic [6:0] left, cend, cc;
	logic [7:0] blank_attr;
	logic [4:0] bk_row;
	logic [6:0] bk_col;

	assign w_ok       = (w_q < 3'(WIN_COUNT));
	assign top        = win_top(w_q);
	assign bottom     = win_bottom(w_q);
	assign last       = 5'(bottom - 5'd1);
	assign left       = win_left(w_q);
	assign cend       = win_col_end(w_q);
	assign cr         = cur_row_q[w_q];
	assign cc         = cur_col_q[w_q];
	assign blank_attr = (w_q == WIN_ERR) ? ATTR_RED : ATTR_GREY;
	assign is_nl      = (ch_q == NL_CODE);
	assign at_end     = (col_q == cend) && (row_q == last);
	assign out_free   = !out_valid_q || !out_stall;

	// Step the cursor back one cell for backspace
	assign bk_row = (cc == left) ? 5'(cr - 5'd1) : cr;
	assign bk_col = (cc == left) ? cend : 7'(cc - 7'd1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (op_q)
					OP_READ: state_d = ST_READ;
					OP_PUT: begin
						if (!w_ok) state_d = ST_DONE;
						else if (ch_q == BKSP_CODE) state_d = ST_BKSP;
						else if (cr == bottom) state_d = ST_SCR_RD;
						else state_d = ST_PUT;
					end
					OP_CLEAR: state_d = w_ok ? ST_WIPE : ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_READ:    state_d = ST_DONE;
			ST_SCR_RD:  state_d = ST_SCR_WR;
			ST_SCR_WR:  state_d = at_end ? ST_LAST_RD : ST_SCR_RD;
			ST_LAST_RD: state_d = ST_LAST_WR;
			ST_LAST_WR: state_d = (col_q == cend) ? ST_PUT : ST_LAST_RD;
			ST_PUT:     state_d = (is_nl && cc != cend) ? ST_PUT : ST_DONE;
			ST_BKSP:    state_d = ST_DONE;
			ST_WIPE:    state_d = at_end ? ST_DONE : ST_WIPE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Store port, cursor update and sweep position
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(row_q, col_q);
		mem_wdata = {blank_attr, SPACE_CODE};
		mem_raddr = cell_addr(row_q, col_q);
		rd_ok_d   = in_store(row_q, col_q);
		cur_we    = 1'b0;
		cur_row_d = cr;
		cur_col_d = cc;
		row_d     = row_q;
		col_d     = col_q;
		cell_d    = cell_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_DECODE: begin
				mem_raddr = cell_addr(rrow_q, rcol_q);
				rd_ok_d   = in_store(rrow_q, rcol_q);
				cell_d    = '0;
				row_d     = (op_q == OP_CLEAR) ? top : 5'(top + 5'd1);
				col_d     = left;
			end
			ST_READ: begin
				cell_d = rd_ok_q ? mem_rd_q : '0;
			end
			ST_SCR_WR: begin
				// Copy the cell just read one row up
				mem_we    = in_store(5'(row_q - 5'd1), col_q);
				mem_waddr = cell_addr(5'(row_q - 5'd1), col_q);
				mem_wdata = rd_ok_q ? mem_rd_q : '0;
				if (col_q == cend) begin
					col_d = left;
					if (row_q != last) row_d = 5'(row_q + 5'd1);
				end else begin
					col_d = 7'(col_q + 7'd1);
				end
			end
			ST_LAST_WR: begin
				// Blank the character of the last row, keep its attribute
				mem_we    = in_store(row_q, col_q);
				mem_wdata = {(rd_ok_q ? mem_rd_q[15:8] : 8'h00), SPACE_CODE};
				if (col_q == cend) begin
					cur_we    = 1'b1;
					cur_row_d = 5'(cr - 5'd1);
				end else begin
					col_d = 7'(col_q + 7'd1);
				end
			end
			ST_PUT: begin
				mem_we    = in_store(cr, cc);
				mem_waddr = cell_addr(cr, cc);
				mem_wdata = is_nl ? {blank_attr, SPACE_CODE} : {attr_q, ch_q};
				cur_we    = 1'b1;
				if (cc == cend) begin
					cur_col_d = left;
					cur_row_d = 5'(cr + 5'd1);
				end else begin
					cur_col_d = 7'(cc + 7'd1);
				end
			end
			ST_BKSP: begin
				if (!(cc == left && cr == top)) begin
					cur_we    = 1'b1;
					cur_row_d = bk_row;
					cur_col_d = bk_col;
					mem_we    = in_store(bk_row, bk_col);
					mem_waddr = cell_addr(bk_row, bk_col);
					mem_wdata = {attr_q, SPACE_CODE};
				end
			end
			ST_WIPE: begin
				mem_we = in_store(row_q, col_q);
				if (col_q == cend) begin
					col_d = left;
					if (row_q == last) begin
						cur_we    = 1'b1;
						cur_row_d = top;
						cur_col_d = left;
					end else begin
						row_d = 5'(row_q + 5'd1);
					end
				end else begin
					col_d = 7'(col_q + 7'd1);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WIN_COUNT; i++) begin
				cur_row_q[i] <= win_top(3'(i));
				cur_col_q[i] <= win_left(3'(i));
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= ADDR_W'(clr_q + 1'b1);
			if (cur_we) begin
				cur_row_q[w_q] <= cur_row_d;
				cur_col_q[w_q] <= cur_col_d;
			end
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Item latch, sweep position and output payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q   <= op;
			w_q    <= window_index;
			ch_q   <= char_code;
			attr_q <= (window_index == WIN_ERR) ? ATTR_RED : {bg_color, fg_color};
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
		row_q   <= row_d;
		col_q   <= col_d;
		cell_q  <= cell_d;
		rd_ok_q <= rd_ok_d;
		if (state_q == ST_DONE && out_free) begin
			cell_char_q  <= cell_q[7:0];
			cell_attr_q  <= cell_q[15:8];
			cursor_row_q <= w_ok ? cr : 5'd0;
			cursor_col_q <= w_ok ? cc : 7'd0;
		end
	end

	// Cell store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) text_mem[mem_waddr] <= mem_wdata;
		mem_rd_q <= text_mem[mem_raddr];
	end

	assign out_valid  = out_valid_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

endmodule
